[hdl/mpsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsd_pkg
// Shared constants, codes and helper functions of the multi-pin sample
// debouncer.
// ----------------------------------------------------------------------------
package mpsd_pkg;

   // Size of the pin bank and depth of each pin's history ring.
   localparam int NUM_PINS      = 32;
   localparam int HISTORY_DEPTH = 4;
   localparam int SLOT_W        = $clog2(HISTORY_DEPTH);

   // Fixed field widths of the interface.
   localparam int LEVELS_W = 32;
   localparam int PIN_IDX_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W = 1;

   // Width of the view through which a pin is selected by its index.
   localparam int VIEW_W = 2 ** PIN_IDX_W;

   // Command codes.
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_PIN_MASK = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULL_UP_MASK   = 1'b1;

   typedef logic [NUM_PINS-1:0] pin_vec_type;

   // Fit a 32-bit word to the pin bank: bits beyond the bank are dropped and
   // missing bits read as zero.
   function automatic pin_vec_type fit_to_bank(input logic [LEVELS_W-1:0] value);
      logic [63:0] wide;
      wide = {32'b0, value};
      return wide[NUM_PINS-1:0];
   endfunction

   // Present a bank vector as a word that a pin index can address; pins
   // outside the bank read as zero.
   function automatic logic [VIEW_W-1:0] bank_view(input pin_vec_type value);
      logic [63:0] wide;
      wide = 64'b0;
      for (int i = 0; i < NUM_PINS; i++) begin
         wide[i] = value[i];
      end
      return wide[VIEW_W-1:0];
   endfunction

endpackage

[hdl/multi_pin_sample_debouncer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pin_sample_debouncer
// Keeps a sample history ring for every pin and answers read beats with the
// debounced state of one pin.
// ----------------------------------------------------------------------------
// A read beat's result beat is registered and offered in the cycle after acceptance.
// Throughput: one beat per cycle; the single result register drains while
// the next beat is taken, so input stalls only while a result is held back.
// A tick beat updates the history ring and gives no result.
// Reset clears history, held states, slot index, masks and result valid.
module multi_pin_sample_debouncer
   import mpsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Configuration port
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   // Request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [LEVELS_W-1:0]   req_pin_levels,
   input  logic [PIN_IDX_W-1:0]  req_read_pin,
   // Response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_pin_state
);

   pin_vec_type                 history_ff [HISTORY_DEPTH];
   pin_vec_type                 history_in [HISTORY_DEPTH];
   pin_vec_type                 held_ff, held_in;
   pin_vec_type                 input_mask_ff, input_mask_in;
   pin_vec_type                 pull_up_ff, pull_up_in;
   logic [SLOT_W-1:0]           slot_ff, slot_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_state_ff, rsp_state_in;

   logic                        req_accept;
   logic                        rsp_free;
   pin_vec_type                 stable_vec;
   pin_vec_type                 value_vec;
   pin_vec_type                 pin_sel;
   logic [VIEW_W-1:0]           input_view;
   logic [VIEW_W-1:0]           stable_view;
   logic [VIEW_W-1:0]           value_view;
   logic [VIEW_W-1:0]           held_view;
   logic                        pin_registered;
   logic                        pin_stable;
   logic                        pin_value;
   logic                        pin_held;

   // The result register is free when empty or when it drains this cycle.
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !rsp_free;
   assign req_accept = req_valid && rsp_free;

   // A pin is stable when every slot of its history matches slot zero.
   always_comb begin
      stable_vec = '1;
      for (int k = 1; k < HISTORY_DEPTH; k++) begin
         stable_vec = stable_vec & ~(history_ff[k] ^ history_ff[0]);
      end
      value_vec = history_ff[0] ^ pull_up_ff;
   end

   // Select the requested pin from each per-pin vector.
   always_comb begin
      input_view     = bank_view(input_mask_ff);
      stable_view    = bank_view(stable_vec);
      value_view     = bank_view(value_vec);
      held_view      = bank_view(held_ff);
      pin_registered = input_view[req_read_pin];
      pin_stable     = stable_view[req_read_pin];
      pin_value      = value_view[req_read_pin];
      pin_held       = held_view[req_read_pin];
      pin_sel        = fit_to_bank(LEVELS_W'(1) << req_read_pin);
   end

   // Next state of history, slot index, held states and result register.
   always_comb begin
      history_in   = history_ff;
      slot_in      = slot_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_state_in = rsp_state_ff;

      if (req_accept) begin
         case (req_command)
            CMD_TICK: begin
               history_in[slot_ff] = fit_to_bank(req_pin_levels);
               if (slot_ff == SLOT_W'(HISTORY_DEPTH - 1)) begin
                  slot_in = '0;
               end else begin
                  slot_in = slot_ff + SLOT_W'(1);
               end
            end
            CMD_READ: begin
               rsp_valid_in = 1'b1;
               if (!pin_registered) begin
                  rsp_state_in = 1'b1;
               end else if (pin_stable) begin
                  rsp_state_in = pin_value;
                  held_in      = (held_ff & ~pin_sel) | (pin_sel & {NUM_PINS{pin_value}});
               end else begin
                  rsp_state_in = pin_held;
               end
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && rsp_stall;
            end
         endcase
      end
   end

   // Configuration writes; unknown indexes leave the masks unchanged.
   always_comb begin
      input_mask_in = input_mask_ff;
      pull_up_in    = pull_up_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_INPUT_PIN_MASK: input_mask_in = fit_to_bank(csr_write_data);
            CSR_PULL_UP_MASK:   pull_up_in    = fit_to_bank(csr_write_data);
            default: begin
               input_mask_in = input_mask_ff;
            end
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HISTORY_DEPTH; k++) begin
            history_ff[k] <= '0;
         end
         held_ff       <= '0;
         slot_ff       <= '0;
         input_mask_ff <= '0;
         pull_up_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         history_ff    <= history_in;
         held_ff       <= held_in;
         slot_ff       <= slot_in;
         input_mask_ff <= input_mask_in;
         pull_up_ff    <= pull_up_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_state_ff <= rsp_state_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pin_state = rsp_state_ff;

endmodule

[hdl/mpsd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsd_checker
// Port-level checks of the debouncer's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module mpsd_checker
   import mpsd_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 req_command,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_pin_state
);

   // A held-back result beat stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("Result beat withdrawn while stalled.");

   // A held-back result beat keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_pin_state))
      else $error("Result value changed while stalled.");

   // Every accepted read beat offers a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == CMD_READ |=> rsp_valid)
      else $error("Read beat gave no result.");

   // A tick beat creates no result of its own.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == CMD_TICK && !(rsp_valid && rsp_stall)
      |=> !rsp_valid)
      else $error("Tick beat gave a result.");

   // The request side is only held back by a waiting result beat.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("Request stalled without a waiting result.");

endmodule

bind multi_pin_sample_debouncer mpsd_checker u_mpsd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_command   (req_command),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_pin_state (rsp_pin_state)
);
